>>> design/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// Depends on nothing; used by every cell and by the top level.
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SQRT_CELLS = 16;
    localparam int DIV_CELLS = 16;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_br;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_req;

    typedef struct packed {
        logic signed [15:0] quat_real;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               not_rotation;
    } t_rsp;

    typedef struct packed {
        logic             bad;
        t_br              br;
        logic [31:0]      v;
        logic [31:0]      res;
        logic [2:0][16:0] num;
        logic [15:0]      root;
        logic [2:0][31:0] rem;
        logic [2:0][15:0] quo;
        logic [2:0]       ovf;
    } t_tok;

endpackage

>>> design/rmq_sqrt_cell.sv
// One digit cell of the square root chain: settles one root bit per cycle while i_adv is high.
// Depends on rmq_pkg.
module rmq_sqrt_cell import rmq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [3:0] i_step,
    input  logic       i_vld,
    input  t_tok       i_tok,
    output logic       o_vld,
    output t_tok       o_tok
);

    logic        r_vld;
    t_tok        r_tok;
    t_tok        n_tok;
    logic [31:0] w_bit;
    logic [31:0] w_sum;

    always_comb begin
        n_tok = i_tok;
        w_bit = 32'd1 << (6'd30 - {1'b0, i_step, 1'b0});
        w_sum = i_tok.res + w_bit;
        if (i_tok.v >= w_sum) begin
            n_tok.v   = i_tok.v - w_sum;
            n_tok.res = (i_tok.res >> 1) + w_bit;
        end else begin
            n_tok.res = i_tok.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

>>> design/rmq_div_prep.sv
// Division setup stage: latches the root, forms dividends, flags overflow.
// Depends on rmq_pkg.
module rmq_div_prep import rmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_vld,
    input  t_tok i_tok,
    output logic o_vld,
    output t_tok o_tok
);

    logic        r_vld;
    t_tok        r_tok;
    t_tok        n_tok;
    logic [15:0] w_root;
    logic [16:0] w_dsr;
    logic [2:0][16:0] w_mag;
    logic [2:0][31:0] w_dvd;

    always_comb begin
        n_tok = i_tok;
        w_root = i_tok.res[15:0];
        w_dsr = {w_root, 1'b0};
        n_tok.root = w_root;
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_tok.num[i][16] ? 17'(-i_tok.num[i]) : i_tok.num[i];
            w_dvd[i] = {1'b0, w_mag[i], FRAC_BITS'(0)} + 32'(w_root);
            n_tok.rem[i] = w_dvd[i];
            n_tok.quo[i] = 16'd0;
            n_tok.ovf[i] = {1'b0, w_dvd[i]} >= {w_dsr, 16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

>>> design/rmq_div_cell.sv
// One restoring division cell: settles one quotient bit of all three lanes.
// Depends on rmq_pkg.
module rmq_div_cell import rmq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [3:0] i_sh,
    input  logic       i_vld,
    input  t_tok       i_tok,
    output logic       o_vld,
    output t_tok       o_tok
);

    logic        r_vld;
    t_tok        r_tok;
    t_tok        n_tok;
    logic [32:0] w_d;

    always_comb begin
        n_tok = i_tok;
        w_d = 33'({i_tok.root, 1'b0}) << i_sh;
        for (int i = 0; i < 3; i++) begin
            if (!i_tok.ovf[i] && ({1'b0, i_tok.rem[i]} >= w_d)) begin
                n_tok.rem[i] = i_tok.rem[i] - w_d[31:0];
                n_tok.quo[i][i_sh] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
        if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

>>> design/rotation_matrix_to_quaternion.sv
// Rotation matrix (Q2.14) to quaternion (Q2.14), Shepperd trace method.
// Pipeline: entry stage, 16 root cells, division setup, 16 divider
// cells, output register. Throughput one request per cycle; the whole chain
// holds while the output register is full and stalled.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// Depends on rmq_pkg, rmq_sqrt_cell, rmq_div_prep, rmq_div_cell.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam logic signed [18:0] ONE = 19'sd1 <<< FRAC_BITS;

    logic w_adv;
    logic r_vld0;
    t_tok r_tok0;
    t_tok n_tok0;
    logic signed [18:0] w_trace;
    logic signed [18:0] w_rad;
    logic signed [16:0] w_a, w_b, w_c, w_d, w_e, w_f;

    logic [SQRT_CELLS:0] w_svld;
    t_tok                w_stok [SQRT_CELLS+1];
    logic [DIV_CELLS:0]  w_dvld;
    t_tok                w_dtok [DIV_CELLS+1];

    logic r_out_vld;
    t_rsp r_rsp;
    t_rsp n_rsp;
    t_tok w_fin;
    logic [2:0][15:0] w_lane;
    logic [15:0] w_diag;

    assign w_adv = !(r_out_vld && i_stall);
    assign o_stall = !w_adv;

    always_comb begin
        n_tok0 = '0;
        w_trace = 19'(i_req.m00) + 19'(i_req.m11) + 19'(i_req.m22);
        w_a = 17'(i_req.m21) - 17'(i_req.m12);
        w_b = 17'(i_req.m02) - 17'(i_req.m20);
        w_c = 17'(i_req.m10) - 17'(i_req.m01);
        w_d = 17'(i_req.m01) + 17'(i_req.m10);
        w_e = 17'(i_req.m02) + 17'(i_req.m20);
        w_f = 17'(i_req.m12) + 17'(i_req.m21);
        if (w_trace > 0) begin
            n_tok0.br = BR_TRACE;
            w_rad = ONE + w_trace;
            n_tok0.num = {w_c, w_b, w_a};
        end else if (i_req.m00 > i_req.m11 && i_req.m00 > i_req.m22) begin
            n_tok0.br = BR_X;
            w_rad = ONE + 19'(i_req.m00) - 19'(i_req.m11) - 19'(i_req.m22);
            n_tok0.num = {w_e, w_d, w_a};
        end else if (i_req.m11 > i_req.m22) begin
            n_tok0.br = BR_Y;
            w_rad = ONE + 19'(i_req.m11) - 19'(i_req.m00) - 19'(i_req.m22);
            n_tok0.num = {w_f, w_d, w_b};
        end else begin
            n_tok0.br = BR_Z;
            w_rad = ONE + 19'(i_req.m22) - 19'(i_req.m00) - 19'(i_req.m11);
            n_tok0.num = {w_f, w_e, w_c};
        end
        n_tok0.bad = (w_rad <= 0);
        n_tok0.v = n_tok0.bad ? 32'd0 : (32'(w_rad[16:0]) << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_adv) begin
            r_vld0 <= i_valid;
        end
        if (w_adv) begin
            r_tok0 <= n_tok0;
        end
    end

    assign w_svld[0] = r_vld0;
    assign w_stok[0] = r_tok0;

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_step  (4'(k)),
            .i_vld   (w_svld[k]),
            .i_tok   (w_stok[k]),
            .o_vld   (w_svld[k+1]),
            .o_tok   (w_stok[k+1])
        );
    end

    rmq_div_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_svld[SQRT_CELLS]),
        .i_tok   (w_stok[SQRT_CELLS]),
        .o_vld   (w_dvld[0]),
        .o_tok   (w_dtok[0])
    );

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        rmq_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_sh    (4'(DIV_CELLS - 1 - k)),
            .i_vld   (w_dvld[k]),
            .i_tok   (w_dtok[k]),
            .o_vld   (w_dvld[k+1]),
            .o_tok   (w_dtok[k+1])
        );
    end

    always_comb begin
        w_fin = w_dtok[DIV_CELLS];
        w_diag = {1'b0, w_fin.root[15:1]};
        for (int i = 0; i < 3; i++) begin
            if (w_fin.ovf[i] || w_fin.quo[i][15]) begin
                w_lane[i] = w_fin.num[i][16] ? 16'h8000 : 16'h7fff;
            end else begin
                w_lane[i] = w_fin.num[i][16] ? 16'(-w_fin.quo[i]) : w_fin.quo[i];
            end
        end
        n_rsp = '0;
        case (w_fin.br)
            BR_TRACE: begin
                n_rsp.quat_real = w_diag;
                n_rsp.quat_x = w_lane[0];
                n_rsp.quat_y = w_lane[1];
                n_rsp.quat_z = w_lane[2];
            end
            BR_X: begin
                n_rsp.quat_real = w_lane[0];
                n_rsp.quat_x = w_diag;
                n_rsp.quat_y = w_lane[1];
                n_rsp.quat_z = w_lane[2];
            end
            BR_Y: begin
                n_rsp.quat_real = w_lane[0];
                n_rsp.quat_x = w_lane[1];
                n_rsp.quat_y = w_diag;
                n_rsp.quat_z = w_lane[2];
            end
            default: begin
                n_rsp.quat_real = w_lane[0];
                n_rsp.quat_x = w_lane[1];
                n_rsp.quat_y = w_lane[2];
                n_rsp.quat_z = w_diag;
            end
        endcase
        if (w_fin.bad) begin
            n_rsp = '0;
            n_rsp.not_rotation = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_dvld[DIV_CELLS];
        end
        if (w_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp = r_rsp;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.not_rotation |->
            o_rsp.quat_real == 16'd0 && o_rsp.quat_x == 16'd0 &&
            o_rsp.quat_y == 16'd0 && o_rsp.quat_z == 16'd0)
        else $error("flagged result carries nonzero quaternion");

    a_hold_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_dvld) && $stable(w_svld))
        else $error("pipeline moved while output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_vld0)
        else $error("valid set after reset");

endmodule

>>> tb/sv/rotation_matrix_to_quaternion_test.sv
// Testbench for rotation_matrix_to_quaternion: drives matrices, predicts each
// quaternion in fixed point and checks every response in order.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 100ps

class quat_scoreboard;
    rmq_pkg::t_rsp pending[$];
    int errors;
    int checked;
    int bad_seen;

    function new();
        errors = 0;
        checked = 0;
        bad_seen = 0;
    endfunction

    function longint isqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 60;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function logic signed [15:0] sat(longint x);
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        return x[15:0];
    endfunction

    function logic signed [15:0] scale(longint num, longint root);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< rmq_pkg::FRAC_BITS) + root) / (root * 2);
        if (q > 65536) q = 65536;
        return sat(num < 0 ? -q : q);
    endfunction

    function void note_request(rmq_pkg::t_req r);
        rmq_pkg::t_rsp e;
        rmq_pkg::t_br br;
        longint a0, a1, a2, b0, b1, b2, c0, c1, c2;
        longint tr, rad, root;
        logic signed [15:0] dg;
        a0 = r.m00; a1 = r.m01; a2 = r.m02;
        b0 = r.m10; b1 = r.m11; b2 = r.m12;
        c0 = r.m20; c1 = r.m21; c2 = r.m22;
        tr = a0 + b1 + c2;
        e = '0;
        if (tr > 0) begin
            br = rmq_pkg::BR_TRACE;
            rad = 16384 + tr;
        end else if (a0 > b1 && a0 > c2) begin
            br = rmq_pkg::BR_X;
            rad = 16384 + a0 - b1 - c2;
        end else if (b1 > c2) begin
            br = rmq_pkg::BR_Y;
            rad = 16384 + b1 - a0 - c2;
        end else begin
            br = rmq_pkg::BR_Z;
            rad = 16384 + c2 - a0 - b1;
        end
        if (rad <= 0) begin
            e.not_rotation = 1'b1;
        end else begin
            root = isqrt(rad <<< rmq_pkg::FRAC_BITS);
            dg = sat(root >>> 1);
            case (br)
                rmq_pkg::BR_TRACE: begin
                    e.quat_real = dg;
                    e.quat_x = scale(c1 - b2, root);
                    e.quat_y = scale(a2 - c0, root);
                    e.quat_z = scale(b0 - a1, root);
                end
                rmq_pkg::BR_X: begin
                    e.quat_real = scale(c1 - b2, root);
                    e.quat_x = dg;
                    e.quat_y = scale(a1 + b0, root);
                    e.quat_z = scale(a2 + c0, root);
                end
                rmq_pkg::BR_Y: begin
                    e.quat_real = scale(a2 - c0, root);
                    e.quat_x = scale(a1 + b0, root);
                    e.quat_y = dg;
                    e.quat_z = scale(b2 + c1, root);
                end
                default: begin
                    e.quat_real = scale(b0 - a1, root);
                    e.quat_x = scale(a2 + c0, root);
                    e.quat_y = scale(b2 + c1, root);
                    e.quat_z = dg;
                end
            endcase
        end
        pending.push_back(e);
    endfunction

    function void check_response(rmq_pkg::t_rsp a);
        rmq_pkg::t_rsp e;
        if (pending.size() == 0) begin
            $error("response with no request pending");
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (a.not_rotation) bad_seen++;
        if (a.quat_real !== e.quat_real) begin
            $error("quat_real exp %0d got %0d", e.quat_real, a.quat_real);
            errors++;
        end
        if (a.quat_x !== e.quat_x) begin
            $error("quat_x exp %0d got %0d", e.quat_x, a.quat_x);
            errors++;
        end
        if (a.quat_y !== e.quat_y) begin
            $error("quat_y exp %0d got %0d", e.quat_y, a.quat_y);
            errors++;
        end
        if (a.quat_z !== e.quat_z) begin
            $error("quat_z exp %0d got %0d", e.quat_z, a.quat_z);
            errors++;
        end
        if (a.not_rotation !== e.not_rotation) begin
            $error("not_rotation exp %0d got %0d", e.not_rotation, a.not_rotation);
            errors++;
        end
    endfunction
endclass

module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    quat_scoreboard sb = new();
    bit sending_done = 1'b0;
    bit hold_done = 1'b0;
    int sent = 0;

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [15:0] near(int c, int spread);
        int v;
        v = c + $urandom_range(2 * spread) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Matrix close to a signed permutation, so every branch gets taken.
    function automatic t_req near_rotation();
        t_req r;
        int p, s, spread;
        logic signed [15:0] e [9];
        p = $urandom_range(5);
        spread = ($urandom_range(3) == 0) ? 16384 : 3000;
        for (int k = 0; k < 9; k++) e[k] = near(0, spread);
        for (int row = 0; row < 3; row++) begin
            int col;
            col = (row + p) % 3;
            if (p >= 3) col = (3 - row + p) % 3;
            s = $urandom_range(1) ? 16384 : -16384;
            e[row * 3 + col] = near(s, spread);
        end
        r = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return r;
    endfunction

    task automatic send(t_req r);
        int gap;
        gap = $urandom_range(3) == 0 ? $urandom_range(10) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(r);
        sent++;
    endtask

    initial begin
        t_req r;
        logic signed [15:0] ext [4];
        ext = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh4000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
              16'sd16384});
        send({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0,
              -16'sd16384});
        send({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
              -16'sd16384});
        send({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0,
              16'sd16384});
        send({-16'sd16384, 16'sd5, 16'sd7, 16'sd3, -16'sd16384, 16'sd9, 16'sd1, 16'sd2,
              -16'sd16384});
        send({-16'sd8000, 16'sd0, 16'sd0, 16'sd0, -16'sd8000, 16'sd0, 16'sd0, 16'sd0,
              -16'sd9000});
        send('0);
        send({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh7fff});
        send({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh8000});
        send({16'sd0, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sd32768, 16'sh7fff,
              16'sh7fff, 16'sh8000, -16'sd32768});
        send({-16'sd32768, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0, 16'sh8000,
              16'sh8000, 16'sh7fff, -16'sd32768});
        send({16'sd0, 16'sh8000, 16'sh7fff, 16'sh7fff, -16'sd1, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sd1});
        for (int k = 0; k < 8; k++) begin
            for (int n = 0; n < 9; n++) r[n * 16 +: 16] = ext[$urandom_range(3)];
            send(r);
        end
        for (int k = 0; k < 1730; k++) begin
            if ($urandom_range(4) == 0) begin
                r = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
            end else begin
                r = near_rotation();
            end
            send(r);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall) sb.check_response(o_rsp);
    end

    initial begin
        int hold;
        @(posedge i_rst_n);
        while (sent < 100) @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_done = 1'b1;
        forever begin
            hold = $urandom_range(2) == 0 ? $urandom_range(10) : 0;
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    initial begin
        wait (sending_done && hold_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d matrices, checked %0d quaternions, %0d flagged as not rotation.",
                 sent, sb.checked, sb.bad_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> sim.f
design/rmq_pkg.sv
design/rmq_sqrt_cell.sv
design/rmq_div_prep.sv
design/rmq_div_cell.sv
design/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_test.sv
